// ===== rtl/lzwe_pkg.sv =====
package lzwe_pkg;

   // default dictionary size in code bits
   localparam int MAX_CODE_WIDTH_DEF = 12;
   localparam int INITIAL_CODE_WIDTH = 9;
   localparam int FIRST_FREE_CODE    = 256;

   // stream tag stored with each hash entry
   localparam int EPOCH_W = 4;

   // request: one uncompressed byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   // result: one packed output byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

endpackage

// ===== rtl/lzwe_ram.sv =====
module lzwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/lzwe_fifo.sv =====
module lzwe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lzwe_engine.sv =====
module lzwe_engine import lzwe_pkg::*; #(
   parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_empty,
   input  req_type in_data,
   output logic    in_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_data,
   output logic    clearing
);

   localparam int HW    = MAX_CODE_WIDTH + 1;
   localparam int KEY_W = MAX_CODE_WIDTH + 8;
   localparam int ENT_W = EPOCH_W + KEY_W + MAX_CODE_WIDTH;
   localparam int NF_W  = MAX_CODE_WIDTH + 1;
   localparam int CW_W  = $clog2(MAX_CODE_WIDTH + 1);
   localparam int ACC_W = MAX_CODE_WIDTH + 7;
   localparam int CNT_W = $clog2(ACC_W + 1);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_PROBE   = 3'd2;
   localparam logic [2:0] S_DRAIN   = 3'd3;
   localparam logic [2:0] S_FINAL   = 3'd4;
   localparam logic [2:0] S_PAD     = 3'd5;
   localparam logic [2:0] S_RESTART = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [7:0]                byte_ff, byte_in;
   logic                      eod_ff, eod_in;
   logic                      final_ff, final_in;
   logic [MAX_CODE_WIDTH-1:0] match_ff, match_in;
   logic                      active_ff, active_in;
   logic [NF_W-1:0]           nf_ff, nf_in;
   logic [CW_W-1:0]           cw_ff, cw_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [EPOCH_W-1:0]        epoch_ff, epoch_in;
   logic [HW-1:0]             addr_ff, addr_in;

   logic                      wr_en;
   logic [HW-1:0]             rd_addr;
   logic [ENT_W-1:0]          wr_data, rd_data;
   logic [HW-1:0]             hash;
   logic [KEY_W-1:0]          key_now;
   logic                      hit, slot_free;
   logic [CW_W-1:0]           w_eff;
   logic [NF_W-1:0]           pow;
   logic [ACC_W-1:0]          acc_put;
   logic [CNT_W-1:0]          cnt_put;

   // hash table of (prefix, byte) keys, tagged with the stream epoch
   lzwe_ram #(.WIDTH(ENT_W), .DEPTH(2 ** HW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // probe address and entry compare
   assign hash      = HW'(match_ff) ^ (HW'(in_data.data_byte) << (HW - 8));
   assign rd_addr   = (state_ff == S_IDLE) ? hash : addr_ff + HW'(1);
   assign key_now   = {match_ff, byte_ff};
   assign slot_free = (rd_data[ENT_W-1 -: EPOCH_W] != epoch_ff);
   assign hit       = !slot_free && (rd_data[MAX_CODE_WIDTH +: KEY_W] == key_now);

   // width grows before the emit when next free code hits the limit
   assign pow   = NF_W'(1) << cw_ff;
   assign w_eff = (cw_ff < CW_W'(MAX_CODE_WIDTH) && nf_ff == pow) ? cw_ff + CW_W'(1) : cw_ff;

   // append current match code to the bit accumulator
   assign acc_put = (acc_ff << w_eff)
                  | (ACC_W'(match_ff) & ~({ACC_W{1'b1}} << w_eff));
   assign cnt_put = cnt_ff + CNT_W'(w_eff);

   assign clearing = (state_ff == S_CLEAR);
   assign in_pop   = (state_ff == S_IDLE) && !in_empty;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      byte_in   = byte_ff;
      eod_in    = eod_ff;
      final_in  = final_ff;
      match_in  = match_ff;
      active_in = active_ff;
      nf_in     = nf_ff;
      cw_in     = cw_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      epoch_in  = epoch_ff;
      addr_in   = addr_ff;
      wr_en     = 1'b0;
      wr_data   = '0;
      out_push  = 1'b0;
      out_data.out_byte  = 8'(acc_ff >> (cnt_ff - CNT_W'(8)));
      out_data.last_byte = final_ff && (cnt_ff == CNT_W'(8));
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + HW'(1);
            if (addr_ff == {HW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!in_empty) begin
               byte_in  = in_data.data_byte;
               eod_in   = in_data.end_of_data;
               final_in = 1'b0;
               if (!active_ff) begin
                  match_in  = MAX_CODE_WIDTH'(in_data.data_byte);
                  active_in = 1'b1;
                  state_in  = in_data.end_of_data ? S_FINAL : S_IDLE;
               end else begin
                  addr_in  = hash;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (hit) begin
               match_in = rd_data[MAX_CODE_WIDTH-1:0];
               state_in = eod_ff ? S_FINAL : S_IDLE;
            end else if (slot_free) begin
               acc_in = acc_put;
               cnt_in = cnt_put;
               cw_in  = w_eff;
               if (!nf_ff[NF_W-1]) begin
                  wr_en   = 1'b1;
                  wr_data = {epoch_ff, key_now, nf_ff[MAX_CODE_WIDTH-1:0]};
                  nf_in   = nf_ff + NF_W'(1);
               end
               match_in = MAX_CODE_WIDTH'(byte_ff);
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + HW'(1);
            end
         end
         S_DRAIN: begin
            if (cnt_ff >= CNT_W'(8)) begin
               if (!out_full) begin
                  out_push = 1'b1;
                  cnt_in   = cnt_ff - CNT_W'(8);
               end
            end else if (final_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = eod_ff ? S_FINAL : S_IDLE;
            end
         end
         S_FINAL: begin
            acc_in   = acc_put;
            cnt_in   = cnt_put;
            cw_in    = w_eff;
            final_in = 1'b1;
            state_in = S_DRAIN;
         end
         S_PAD: begin
            out_data.out_byte  = 8'(acc_ff << (CNT_W'(8) - cnt_ff));
            out_data.last_byte = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_RESTART;
            end else if (!out_full) begin
               out_push = 1'b1;
               state_in = S_RESTART;
            end
         end
         S_RESTART: begin
            active_in = 1'b0;
            nf_in     = NF_W'(FIRST_FREE_CODE);
            cw_in     = CW_W'(INITIAL_CODE_WIDTH);
            cnt_in    = '0;
            final_in  = 1'b0;
            eod_in    = 1'b0;
            if (epoch_ff == {EPOCH_W{1'b1}}) begin
               epoch_in = EPOCH_W'(1);
               addr_in  = '0;
               state_in = S_CLEAR;
            end else begin
               epoch_in = epoch_ff + EPOCH_W'(1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         addr_ff   <= '0;
         epoch_ff  <= EPOCH_W'(1);
         active_ff <= 1'b0;
         final_ff  <= 1'b0;
         eod_ff    <= 1'b0;
         nf_ff     <= NF_W'(FIRST_FREE_CODE);
         cw_ff     <= CW_W'(INITIAL_CODE_WIDTH);
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         epoch_ff  <= epoch_in;
         active_ff <= active_in;
         final_ff  <= final_in;
         eod_ff    <= eod_in;
         nf_ff     <= nf_in;
         cw_ff     <= cw_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      match_ff <= match_in;
      acc_ff   <= acc_in;
   end

endmodule

// ===== rtl/lzw_variable_width_encoder.sv =====
// LZW compressor with variable code width, one byte per request.
// Request channel: push req_data while req_full is low; the last byte of a
// stream carries end_of_data, which flushes the final code, pads the tail
// with zeros and starts a fresh dictionary for the next stream.
// Result channel: packed code bytes, MSB first, wait in a 4-entry queue;
// rsp_data is valid while rsp_empty is low and leaves on rsp_pop.
// last_byte marks the final byte of each stream.
// A byte that extends the match holds the sequencer for the queue pop with
// table read, then the compare; each hash collision adds a probe of the next
// slot, as the table has a single read port. A byte that ends a match adds
// the code append plus the drain, one byte per cycle into the result queue
// while it has room. The end of a stream adds the final code, its drain, a
// pad step and a restart step. The first byte of a stream only opens a match.
// A 2-entry request queue decouples the front from the sequencer, so
// requests land until it fills while the back end works or waits on rsp_pop.
// When the result queue is full the sequencer stalls; nothing is dropped.
// After reset, and after every 15th stream, the hash table is swept clean
// over its 2^(MAX_CODE_WIDTH+1) entries (8192 by default), req_full held high.
module lzw_variable_width_encoder import lzwe_pkg::*; #(
   parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_full, q_empty, q_pop, clearing;
   req_type q_data;
   logic    o_push, o_full;
   rsp_type o_data;

   assign req_full = q_full || clearing;

   // front: request queue
   lzwe_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !clearing),
      .push_data (req_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // back: dictionary and bit packing
   lzwe_engine #(.MAX_CODE_WIDTH(MAX_CODE_WIDTH)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_empty (q_empty),
      .in_data  (q_data),
      .in_pop   (q_pop),
      .out_full (o_full),
      .out_push (o_push),
      .out_data (o_data),
      .clearing (clearing)
   );

   // result queue
   lzwe_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_data),
      .full      (o_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

`ifndef ASSERT_OFF
   a_full_after_reset: assert property (@(posedge clock) $past(reset) |-> req_full)
      else $error("request accepted during table sweep");
   a_empty_after_reset: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result present right after reset");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(o_push && o_full))
      else $error("result pushed into full queue");
   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset) !(clearing && q_pop))
      else $error("request taken during table sweep");
`endif

endmodule

// ===== test/lzw_variable_width_encoder_tb.sv =====
`timescale 1ns / 1ps

module lzw_variable_width_encoder_tb;
   import lzwe_pkg::*;

   localparam int TABLE_SIZE = 1 << MAX_CODE_WIDTH_DEF;
   localparam int HOLD_CYCLES = 400;

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   lzw_variable_width_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // encoder model state
   int          code_of_string[int];
   int          cur_code;
   bit          in_match;
   int          free_code;
   int          code_bits;
   longint      pending_bits;
   int          pending_count;
   rsp_type     step_bytes[$];
   rsp_type     expected_bytes[$];

   int          error_count;
   int          send_idle;
   int          recv_idle;
   int          hold_request;

   // directed request table; typed results only for single-byte streams
   typedef struct {
      logic [7:0]  data_byte;
      logic        end_of_data;
      bit          typed;
      int          typed_count;
      logic [7:0]  typed_byte [2];
   } directed_row;

   directed_row directed_rows[$];
   directed_row pending_row;
   bit          row_typed_q[$];
   directed_row row_q[$];

   function automatic void clear_encoder();
      code_of_string.delete();
      cur_code      = 0;
      in_match      = 0;
      free_code     = FIRST_FREE_CODE;
      code_bits     = INITIAL_CODE_WIDTH;
      pending_bits  = 0;
      pending_count = 0;
   endfunction

   function automatic void grow_width();
      if (code_bits < MAX_CODE_WIDTH_DEF && free_code == (1 << code_bits))
         code_bits++;
   endfunction

   // append one code and drain whole bytes
   function automatic void pack_code(int code);
      rsp_type r;
      pending_bits  = (pending_bits << code_bits) | (code & ((1 << code_bits) - 1));
      pending_count += code_bits;
      while (pending_count >= 8) begin
         r.out_byte  = 8'(pending_bits >> (pending_count - 8));
         r.last_byte = 1'b0;
         step_bytes = {step_bytes, r};
         pending_count -= 8;
      end
      pending_bits &= (64'd1 << pending_count) - 1;
   endfunction

   // one request through the encoder model, bytes land in step_bytes
   function automatic void encode_byte(logic [7:0] b, logic eod);
      int      key;
      rsp_type r;
      step_bytes.delete();
      if (!in_match) begin
         cur_code = b;
         in_match = 1;
      end else begin
         key = (cur_code << 8) | b;
         if (code_of_string.exists(key)) begin
            cur_code = code_of_string[key];
         end else begin
            grow_width();
            pack_code(cur_code);
            if (free_code < TABLE_SIZE) begin
               code_of_string[key] = free_code;
               free_code++;
            end
            cur_code = b;
         end
      end
      if (eod) begin
         grow_width();
         pack_code(cur_code);
         if (pending_count != 0) begin
            r.out_byte  = 8'(pending_bits << (8 - pending_count));
            r.last_byte = 1'b0;
            step_bytes = {step_bytes, r};
         end
         if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].last_byte = 1'b1;
         clear_encoder();
      end
   endfunction

   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      $display("%0t: %s: got byte %02h last %0b, want byte %02h last %0b",
               $realtime, what, got.out_byte, got.last_byte,
               want.out_byte, want.last_byte);
      error_count++;
   endtask

   // request monitor: predict on every accepted request
   always @(posedge clock) begin
      rsp_type     r;
      directed_row row;
      if (!reset && req_push && !req_full) begin
         encode_byte(req_data.data_byte, req_data.end_of_data);
         if (row_typed_q.size() > 0 && row_typed_q.pop_front()) begin
            row = row_q.pop_front();
            for (int i = 0; i < row.typed_count; i++) begin
               r.out_byte  = row.typed_byte[i];
               r.last_byte = (i == row.typed_count - 1);
               expected_bytes = {expected_bytes, r};
            end
         end else begin
            foreach (step_bytes[i])
               expected_bytes = {expected_bytes, step_bytes[i]};
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && !rsp_empty && rsp_pop) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", rsp_data, '0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_data, want);
            else if (rsp_data.last_byte !== want.last_byte)
               report_mismatch("last_byte", rsp_data, want);
         end
      end
   end

   // receiver with random stalls and long hold-offs on request
   always @(negedge clock) begin
      int hold_left;
      int hold_seen;
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_left = 0;
         hold_seen = 0;
      end else if (hold_seen != hold_request) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
         rsp_pop   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_request(logic [7:0] b, logic eod, bit typed, directed_row row);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      row_typed_q = {row_typed_q, typed};
      if (typed)
         row_q = {row_q, row};
      req_push <= 1'b1;
      req_data <= '{data_byte: b, end_of_data: eod};
      do
         @(posedge clock);
      while (req_full);
      @(negedge clock);
   endtask

   // one stream of random bytes, mostly from a narrow alphabet to build matches
   task automatic send_stream(int len);
      logic [7:0] base;
      logic [7:0] b;
      directed_row none;
      base = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) < 7)
            b = base + 8'($urandom_range(3));
         else
            b = 8'($urandom);
         send_request(b, i == len - 1, 0, none);
      end
   endtask

   function automatic directed_row make_row(logic [7:0] b, logic eod, bit typed,
                                            int cnt, logic [7:0] b0, logic [7:0] b1);
      directed_row row;
      row.data_byte   = b;
      row.end_of_data = eod;
      row.typed       = typed;
      row.typed_count = cnt;
      row.typed_byte  = '{b0, b1};
      return row;
   endfunction

   // run limit
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      string abab;
      int    sent;
      int    len;
      error_count  = 0;
      send_idle    = 0;
      recv_idle    = 0;
      hold_request = 0;
      req_push     = 1'b0;
      req_data     = '0;
      clear_encoder();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-byte streams: the code alone at 9 bits, then zero padding
      directed_rows = {directed_rows, make_row(8'h00, 1, 1, 2, 8'h00, 8'h00)};
      directed_rows = {directed_rows, make_row(8'hff, 1, 1, 2, 8'h7f, 8'h80)};
      directed_rows = {directed_rows, make_row(8'ha5, 1, 1, 2, 8'h52, 8'h80)};
      directed_rows = {directed_rows, make_row(8'h5a, 1, 1, 2, 8'h2d, 8'h00)};
      // repeated pattern grows matches
      abab = "ABABABAB";
      foreach (abab[i])
         directed_rows = {directed_rows,
                          make_row(abab[i], i == abab.len() - 1, 0, 0, 0, 0)};
      // run of one byte, extremes of the byte field
      for (int i = 0; i < 7; i++)
         directed_rows = {directed_rows, make_row(8'hff, 0, 0, 0, 0, 0)};
      directed_rows = {directed_rows, make_row(8'h00, 0, 0, 0, 0, 0)};
      directed_rows = {directed_rows, make_row(8'h80, 1, 0, 0, 0, 0)};

      foreach (directed_rows[i])
         send_request(directed_rows[i].data_byte, directed_rows[i].end_of_data,
                      directed_rows[i].typed, directed_rows[i]);
      req_push <= 1'b0;

      // one long stream that widens codes to 10 bits
      for (int i = 0; i < 280; i++) begin
         send_request(8'($urandom), i == 279, 0, directed_rows[0]);
         if (i == 100)
            hold_request++;
      end

      // random streams over the idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 52; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 52; end
            default: begin send_idle = 23; recv_idle = 23; end
         endcase
         if (phase == 2)
            hold_request++;
         sent = 0;
         while (sent < 20) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            send_stream(len);
            sent += len;
         end
      end
      req_push <= 1'b0;

      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
